[hdl/iilu_pkg.sv]
// ============================================================================
// iilu_pkg
// Shared constants and types for the indexed insert/delete list unit:
// field widths, command and status codes, and the per-cell operation word.
// ============================================================================
package iilu_pkg;

   // Default configuration
   localparam int CAPACITY_DEFAULT   = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the request and response items
   localparam int COMMAND_W    = 3;
   localparam int INDEX_W      = 7;
   localparam int WRITE_DATA_W = 32;
   localparam int STATUS_W     = 2;
   localparam int READ_DATA_W  = 32;
   localparam int COUNT_W      = 6;

   // Command codes
   localparam logic [COMMAND_W-1:0] CMD_INSERT    = 3'd0;
   localparam logic [COMMAND_W-1:0] CMD_READ      = 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_OVERWRITE = 3'd2;
   localparam logic [COMMAND_W-1:0] CMD_POP       = 3'd3;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE    = 3'd4;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR     = 3'd5;
   localparam logic [COMMAND_W-1:0] CMD_REVERSE   = 3'd6;
   localparam logic [COMMAND_W-1:0] CMD_APPEND    = 3'd7;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // Operation broadcast to every cell of the row
   typedef struct packed {
      logic shift_up;    // cells above the position take the lower neighbor
      logic shift_down;  // cells at and above the position take the upper neighbor
      logic load;        // cell at the position takes the write data
   } cell_op_type;

endpackage

[hdl/iilu_if.sv]
// ============================================================================
// iilu_if
// Valid/ready channels of the list unit: the command request channel and the
// result response channel.
// ============================================================================
interface iilu_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [iilu_pkg::COMMAND_W-1:0]            command;
   logic signed [iilu_pkg::INDEX_W-1:0]       index;
   logic [iilu_pkg::WRITE_DATA_W-1:0]         write_data;

   modport source (output valid, output command, output index, output write_data,
                   input ready);
   modport sink   (input valid, input command, input index, input write_data,
                   output ready);
endinterface

interface iilu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [iilu_pkg::STATUS_W-1:0]       status;
   logic [iilu_pkg::READ_DATA_W-1:0]    read_data;
   logic [iilu_pkg::COUNT_W-1:0]        count;

   modport source (output valid, output status, output read_data, output count,
                   input ready);
   modport sink   (input valid, input status, input read_data, input count,
                   output ready);
endinterface

[hdl/iilu_cell.sv]
// ============================================================================
// iilu_cell
// One storage cell of the list row. Each cycle it holds, takes its lower
// neighbor (insert), its upper neighbor (remove) or the write data.
// ============================================================================
module iilu_cell #(
   parameter int DATA_WIDTH = iilu_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W      = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  iilu_pkg::cell_op_type   op,
   input  logic [IDX_W-1:0]        pos,
   input  logic [DATA_WIDTH-1:0]   wr_data,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   output logic [DATA_WIDTH-1:0]   data_q
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // Next value from the broadcast operation and this cell's place in the row
   always_comb begin
      data_in = data_ff;
      if (op.shift_down) begin
         if (MY_POS >= pos) data_in = right_data;
      end else if (op.shift_up) begin
         if (MY_POS > pos) begin
            data_in = left_data;
         end else if (MY_POS == pos) begin
            data_in = wr_data;
         end
      end else if (op.load && (MY_POS == pos)) begin
         data_in = wr_data;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

[hdl/iilu_ctrl.sv]
// ============================================================================
// iilu_ctrl
// Command decode: resolves the index against the count, checks range, empty
// and full, maps the logical position onto the cell row through the
// orientation flag, and produces the cell operation and next list state.
// ============================================================================
module iilu_ctrl #(
   parameter int CAPACITY = iilu_pkg::CAPACITY_DEFAULT,
   parameter int IDX_W    = 5,
   parameter int CNT_W    = 6
) (
   input  logic                                  fire,
   input  logic [iilu_pkg::COMMAND_W-1:0]        command,
   input  logic signed [iilu_pkg::INDEX_W-1:0]   index,
   input  logic [CNT_W-1:0]                      count,
   input  logic                                  reversed,
   output iilu_pkg::cell_op_type                 op,
   output logic [IDX_W-1:0]                      pos,
   output logic                                  read_en,
   output logic [iilu_pkg::STATUS_W-1:0]         status,
   output logic [CNT_W-1:0]                      count_in,
   output logic                                  reversed_in
);

   localparam int RW = ((CNT_W > iilu_pkg::INDEX_W) ? CNT_W : iilu_pkg::INDEX_W) + 2;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic signed [RW-1:0] idx_s;
   logic signed [RW-1:0] cnt_s;
   logic signed [RW-1:0] res_s;
   logic signed [RW-1:0] rem_phys;
   logic signed [RW-1:0] ins_phys;
   logic signed [RW-1:0] app_phys;
   logic                 in_range;
   logic                 ins_ok;
   logic                 full;
   logic                 empty;

   // Index resolution: a negative index counts back from the end
   always_comb begin
      idx_s    = {{(RW-iilu_pkg::INDEX_W){index[iilu_pkg::INDEX_W-1]}}, index};
      cnt_s    = $signed({{(RW-CNT_W){1'b0}}, count});
      res_s    = index[iilu_pkg::INDEX_W-1] ? (idx_s + cnt_s) : idx_s;
      in_range = !res_s[RW-1] && (res_s < cnt_s);
      ins_ok   = !res_s[RW-1] && (res_s <= cnt_s);
      full     = (count == FULL_COUNT);
      empty    = (count == '0);
   end

   // Logical to physical position; a reversed list is stored back to front
   always_comb begin
      rem_phys = reversed ? (cnt_s - res_s - RW'(1)) : res_s;
      ins_phys = reversed ? (cnt_s - res_s) : res_s;
      app_phys = reversed ? '0 : cnt_s;
   end

   // Command decode
   always_comb begin
      op          = '0;
      pos         = '0;
      read_en     = 1'b0;
      status      = iilu_pkg::ST_OK;
      count_in    = count;
      reversed_in = reversed;
      case (command)
         iilu_pkg::CMD_INSERT: begin
            if (!ins_ok) begin
               status = iilu_pkg::ST_RANGE;
            end else if (full) begin
               status = iilu_pkg::ST_FULL;
            end else begin
               op.shift_up = fire;
               pos         = ins_phys[IDX_W-1:0];
               count_in    = count + CNT_W'(1);
            end
         end
         iilu_pkg::CMD_APPEND: begin
            if (full) begin
               status = iilu_pkg::ST_FULL;
            end else begin
               op.shift_up = fire;
               pos         = app_phys[IDX_W-1:0];
               count_in    = count + CNT_W'(1);
            end
         end
         iilu_pkg::CMD_READ, iilu_pkg::CMD_OVERWRITE,
         iilu_pkg::CMD_POP, iilu_pkg::CMD_REMOVE: begin
            if (!in_range) begin
               status = empty ? iilu_pkg::ST_EMPTY : iilu_pkg::ST_RANGE;
            end else begin
               pos     = rem_phys[IDX_W-1:0];
               read_en = (command == iilu_pkg::CMD_READ) || (command == iilu_pkg::CMD_POP);
               if (command == iilu_pkg::CMD_OVERWRITE) begin
                  op.load = fire;
               end else if ((command == iilu_pkg::CMD_POP) ||
                            (command == iilu_pkg::CMD_REMOVE)) begin
                  op.shift_down = fire;
                  count_in      = count - CNT_W'(1);
               end
            end
         end
         iilu_pkg::CMD_CLEAR: begin
            count_in    = '0;
            reversed_in = 1'b0;
         end
         iilu_pkg::CMD_REVERSE: begin
            reversed_in = !reversed;
         end
         default: begin
            status = iilu_pkg::ST_OK;
         end
      endcase
   end

endmodule

[hdl/indexed_insert_delete_list_unit.sv]
// ============================================================================
// indexed_insert_delete_list_unit
// Ordered list with indexed insert, append, read, overwrite, pop, remove,
// clear and reverse, held in a row of shifting cells.
// ============================================================================
// Each command is decoded, applied to the cell row and its response captured
// in the output register at the edge of the transfer, and the next command
// is taken in the following cycle as long as the response side keeps
// taking results. This speed comes from the cell row, where the cells from
// the position upward all load from a neighbor or the write data at the same
// edge for an insert or remove, and from an orientation flag that a reverse
// flips instead of moving data. Elements read through one position mux over
// the row. There is no clearing pass after reset; the list starts empty.
module indexed_insert_delete_list_unit #(
   parameter int CAPACITY   = iilu_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = iilu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   iilu_req_if.sink     req_link,
   iilu_rsp_if.source   rsp_link
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int WW    = (DATA_WIDTH > iilu_pkg::WRITE_DATA_W) ? DATA_WIDTH
                                                                : iilu_pkg::WRITE_DATA_W;
   localparam int CW    = (CNT_W > iilu_pkg::COUNT_W) ? CNT_W : iilu_pkg::COUNT_W;

   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          reversed_ff;
   logic                          reversed_in;
   logic                          rsp_valid_ff;
   logic [iilu_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [iilu_pkg::READ_DATA_W-1:0] rsp_data_ff;
   logic [iilu_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic                          fire;
   iilu_pkg::cell_op_type         cell_op;
   logic [IDX_W-1:0]              pos;
   logic                          read_en;
   logic [iilu_pkg::STATUS_W-1:0] status;
   logic [WW-1:0]                 wr_wide;
   logic [DATA_WIDTH-1:0]         wr_data;
   logic [DATA_WIDTH-1:0]         rd_sel;
   logic [WW-1:0]                 rd_wide;
   logic [CW-1:0]                 cnt_wide;
   logic [DATA_WIDTH-1:0]         cell_q [CAPACITY];

   // Handshake: a new command is taken whenever the output register frees up
   assign req_link.ready = !rsp_valid_ff || rsp_link.ready;
   assign fire           = req_link.valid && req_link.ready;

   // Write data kept in the element width
   assign wr_wide = WW'(req_link.write_data);
   assign wr_data = wr_wide[DATA_WIDTH-1:0];

   // Command decode
   iilu_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .fire        (fire),
      .command     (req_link.command),
      .index       (req_link.index),
      .count       (count_ff),
      .reversed    (reversed_ff),
      .op          (cell_op),
      .pos         (pos),
      .read_en     (read_en),
      .status      (status),
      .count_in    (count_in),
      .reversed_in (reversed_in)
   );

   // Cell row; each cell sees its two neighbors
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (k == 0) begin : g_first
         assign left_d = wr_data;
      end else begin : g_inner_l
         assign left_d = cell_q[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_d = cell_q[k];
      end else begin : g_inner_r
         assign right_d = cell_q[k+1];
      end
      iilu_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (pos),
         .wr_data    (wr_data),
         .left_data  (left_d),
         .right_data (right_d),
         .data_q     (cell_q[k])
      );
   end

   // Read path: zero unless a successful read or pop
   assign rd_sel   = read_en ? cell_q[pos] : '0;
   assign rd_wide  = WW'(rd_sel);
   assign cnt_wide = CW'(count_in);

   // List state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reversed_ff <= 1'b0;
      end else if (fire) begin
         count_ff    <= count_in;
         reversed_ff <= reversed_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_link.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= status;
         rsp_data_ff   <= rd_wide[iilu_pkg::READ_DATA_W-1:0];
         rsp_count_ff  <= cnt_wide[iilu_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_link.valid     = rsp_valid_ff;
   assign rsp_link.status    = rsp_status_ff;
   assign rsp_link.read_data = rsp_data_ff;
   assign rsp_link.count     = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      fire && (status != iilu_pkg::ST_OK) |=> count_ff == $past(count_ff))
      else $error("failed command changed the element count");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != iilu_pkg::ST_OK) |-> rsp_data_ff == '0)
      else $error("failed command returned nonzero read data");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      fire && (req_link.command == iilu_pkg::CMD_CLEAR) |=> count_ff == '0)
      else $error("clear left elements in the list");

endmodule
